// ===== src/mcdcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcdcr_pkg - shared types and constants of the deadband change reporter
// Field widths, configuration register indexes, result cause codes and the
// control words passed between the lanes, the merge stage and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none
package mcdcr_pkg;

  // fixed field widths of the stream words
  localparam int unsigned SAMPLE_FIELD_W = 10;
  localparam int unsigned NUM_SAMPLES    = 8;
  localparam int unsigned IN_TDATA_W     = 80;
  localparam int unsigned CHAN_W         = 3;
  localparam int unsigned LEVEL_W        = 10;
  localparam int unsigned OUT_TDATA_W    = 16;

  // configuration register widths
  localparam int unsigned ACT_W    = 4;
  localparam int unsigned DB_W     = 10;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // tick counter saturates here
  localparam logic [PERIOD_W-1:0] COUNT_TOP = 16'hFFFF;

  // reset values of the configuration registers
  localparam logic [ACT_W-1:0]    ACT_RESET    = 4'd8;
  localparam logic [DB_W-1:0]     DB_RESET     = 10'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd300;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_PERIOD   = 2'd2
  } cfg_idx_t;

  // cause codes carried in tuser
  localparam logic CAUSE_CHANGE  = 1'b0;
  localparam logic CAUSE_REFRESH = 1'b1;

  // decision of the merge stage for one tick
  typedef struct packed {
    logic hit;    // some active channel moved beyond the deadband
    logic emit;   // a snapshot follows this tick
    logic cause;  // cause code of that snapshot
  } mcdcr_dec_t;

  // snapshot request handed to the emitter
  typedef struct packed {
    logic             start;
    logic             cause;
    logic [ACT_W-1:0] count;
  } mcdcr_snap_t;

endpackage : mcdcr_pkg
`default_nettype wire

// ===== src/multi_channel_deadband_change_reporter_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_deadband_change_reporter_unit - deadband change reporter
// Checks every active channel of a tick against its last reported level in
// parallel lanes and emits a snapshot of all active channels on the first
// change beyond the deadband or on a periodic refresh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | slave     | in_tvalid/in_tready  | tdata: sample_0..sample_7
//   out_    | master    | out_tvalid/out_tready| tdata: channel, level; tuser:
//           |           |                      | cause; tlast: last_of_report
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A tick is checked in the cycle it is accepted. A snapshot carries one word
// per active channel (up to MAX_CHANNELS), the emitter reading one stored
// level per word and holding each word until out_tready takes it.
// The next tick is taken in the cycle the final word of a snapshot is taken.
// Reset clears the stored levels and the tick counter and loads the
// register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_channel_deadband_change_reporter_unit
  import mcdcr_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // sample_0[9:0] .. sample_7[79:70]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // channel[2:0], level[12:3], zero pad
  output logic                        out_tuser,  // cause
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ACT_W-1:0]    act_r,    act_nxt;
  logic [DB_W-1:0]     db_r,     db_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] count_r,  count_nxt;
  logic [SAMPLE_BITS-1:0] level_r [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] level_nxt [MAX_CHANNELS];

  logic [SAMPLE_BITS-1:0]  sample [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] changed;
  logic [MAX_CHANNELS-1:0] active;
  logic [MAX_CHANNELS-1:0] wr_en;
  logic [ACT_W-1:0]        n_act;
  logic                    refresh_due;
  logic                    in_acc;
  logic                    busy;
  mcdcr_dec_t              dec;
  mcdcr_snap_t             snap;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    act_nxt    = act_r;
    db_nxt     = db_r;
    period_nxt = period_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE:   act_nxt    = cfg_data[ACT_W-1:0];
        CFG_DEADBAND: db_nxt     = cfg_data[DB_W-1:0];
        CFG_PERIOD:   period_nxt = cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the channel count and build the lane mask
  always_comb begin
    n_act = (act_r > ACT_W'(MAX_CHANNELS)) ? ACT_W'(MAX_CHANNELS) : act_r;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      active[i] = ACT_W'(i) < n_act;
      sample[i] = SAMPLE_BITS'(in_tdata[i*SAMPLE_FIELD_W +: SAMPLE_FIELD_W]);
    end
  end

  assign refresh_due = count_r > period_r;
  assign in_tready   = ~busy | (out_tvalid & out_tready & out_tlast);
  assign in_acc      = in_tvalid & in_tready;

  // one deadband check per channel
  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    mcdcr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .sample   (sample[g]),
      .stored   (level_r[g]),
      .deadband (db_r),
      .changed  (changed[g])
    );
  end

  mcdcr_merge #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_merge (
    .changed     (changed),
    .active      (active),
    .refresh_due (refresh_due),
    .any_active  (n_act != '0),
    .wr_en       (wr_en),
    .dec         (dec)
  );

  // update levels and the tick counter on an accepted tick
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      level_nxt[i] = (in_acc && wr_en[i]) ? sample[i] : level_r[i];
    end
    if (in_acc) begin
      if (dec.hit) begin
        count_nxt = '0;
      end else if (refresh_due) begin
        count_nxt = PERIOD_W'(1);
      end else if (count_r != COUNT_TOP) begin
        count_nxt = count_r + PERIOD_W'(1);
      end
    end
    snap.start = in_acc & dec.emit;
    snap.cause = dec.cause;
    snap.count = n_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= ACT_RESET;
      db_r     <= DB_RESET;
      period_r <= PERIOD_RESET;
      count_r  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        level_r[i] <= '0;
      end
    end else begin
      act_r    <= act_nxt;
      db_r     <= db_nxt;
      period_r <= period_nxt;
      count_r  <= count_nxt;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        level_r[i] <= level_nxt[i];
      end
    end
  end

  mcdcr_emit #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap       (snap),
    .levels     (level_r),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a change always restarts the counter
  a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && dec.hit |=> count_r == '0)
    else $error("tick counter not cleared after a change");

  // a quiet tick not past the period advances the counter by one
  a_quiet_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !dec.hit && !refresh_due && count_r != COUNT_TOP
    |=> count_r == $past(count_r) + PERIOD_W'(1))
    else $error("tick counter did not advance on a quiet tick");

  // input is held off only while a snapshot is on the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no snapshot pending");

  // a started snapshot shows its first word next cycle
  a_snap_start: assert property (@(posedge clk) disable iff (!rst_n)
    snap.start |=> out_tvalid && out_tdata[CHAN_W-1:0] == '0)
    else $error("snapshot did not start at channel zero");

endmodule : multi_channel_deadband_change_reporter_unit
`default_nettype wire

// ===== src/mcdcr_lane.sv =====
// ----------------------------------------------------------------------------
// mcdcr_lane - deadband check of one channel
// Forms the absolute difference between the new sample and the stored level
// and flags a change when it is larger than the deadband.
// ----------------------------------------------------------------------------
`default_nettype none
module mcdcr_lane
  import mcdcr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [SAMPLE_BITS-1:0] stored,
  input  wire logic [DB_W-1:0]        deadband,
  output logic                        changed
);

  localparam int unsigned CMP_W = (SAMPLE_BITS > DB_W) ? SAMPLE_BITS : DB_W;

  logic [SAMPLE_BITS-1:0] diff;

  // take the magnitude of the step, then compare at a common width
  always_comb begin
    if (sample > stored) begin
      diff = sample - stored;
    end else begin
      diff = stored - sample;
    end
    changed = CMP_W'(diff) > CMP_W'(deadband);
  end

endmodule : mcdcr_lane
`default_nettype wire

// ===== src/mcdcr_merge.sv =====
// ----------------------------------------------------------------------------
// mcdcr_merge - combine the lane flags of one tick
// Picks the lowest active channel that changed, works out which stored levels
// take their new sample and decides whether a snapshot follows.
// ----------------------------------------------------------------------------
`default_nettype none
module mcdcr_merge
  import mcdcr_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  wire logic [MAX_CHANNELS-1:0] changed,
  input  wire logic [MAX_CHANNELS-1:0] active,
  input  wire logic                    refresh_due,
  input  wire logic                    any_active,
  output logic [MAX_CHANNELS-1:0]      wr_en,
  output mcdcr_dec_t                   dec
);

  logic [MAX_CHANNELS-1:0] clear_before;
  logic [MAX_CHANNELS-1:0] first;
  logic                    seen;

  // priority scan: a lane counts only while no lower active lane changed
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      clear_before[i] = ~seen;
      first[i]        = active[i] & changed[i] & ~seen;
      seen            = seen | (active[i] & changed[i]);
    end
  end

  // lanes ahead of the change store their sample only when a refresh is due
  always_comb begin
    wr_en     = first | (clear_before & active & {MAX_CHANNELS{refresh_due}});
    dec.hit   = seen;
    dec.emit  = any_active & (seen | refresh_due);
    dec.cause = seen ? CAUSE_CHANGE : CAUSE_REFRESH;
  end

endmodule : mcdcr_merge
`default_nettype wire

// ===== src/mcdcr_emit.sv =====
// ----------------------------------------------------------------------------
// mcdcr_emit - snapshot sequencer
// Walks the active channels from zero upward and presents one result word per
// channel, read from the stored levels, with tlast on the final channel.
// ----------------------------------------------------------------------------
`default_nettype none
module mcdcr_emit
  import mcdcr_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mcdcr_snap_t            snap,
  input  wire logic [SAMPLE_BITS-1:0] levels [MAX_CHANNELS],
  output logic                        busy,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // channel[2:0], level[12:3], zero pad
  output logic                        out_tuser,  // cause
  output logic                        out_tlast
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic             busy_r,  busy_nxt;
  logic [IDX_W-1:0] idx_r,   idx_nxt;
  logic [ACT_W-1:0] cnt_r,   cnt_nxt;
  logic             cause_r, cause_nxt;
  logic             last;
  logic             take;
  logic [SAMPLE_BITS-1:0] lvl;

  assign last = (ACT_W'(idx_r) + ACT_W'(1)) == cnt_r;
  assign take = busy_r & out_tready;
  assign lvl  = levels[idx_r];

  // start a snapshot, advance on each word taken, drop busy after the last
  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cause_nxt = cause_r;
    if (snap.start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      cnt_nxt   = snap.count;
      cause_nxt = snap.cause;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // snapshot length and cause hold no control meaning outside a snapshot
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    cause_r <= cause_nxt;
  end

  // present the current word
  always_comb begin
    busy       = busy_r;
    out_tvalid = busy_r;
    out_tdata  = {{(OUT_TDATA_W-CHAN_W-LEVEL_W){1'b0}}, LEVEL_W'(lvl), CHAN_W'(idx_r)};
    out_tuser  = cause_r;
    out_tlast  = last;
  end

endmodule : mcdcr_emit
`default_nettype wire

// ===== verif/multi_channel_deadband_change_reporter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_deadband_change_reporter_unit_tb - self-checking bench
// Streams sample ticks into the reporter under several register settings and
// idle patterns, predicts every snapshot word from a behavioural copy of the
// stored levels and tick counter, and compares each word taken at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module multi_channel_deadband_change_reporter_unit_tb;
  import mcdcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LEVEL_MAX   = (1 << LEVEL_W) - 1;

  // one snapshot word as seen at the output
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               cause;
    logic               last;
  } report_word_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // sample_0[9:0] .. sample_7[79:70]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // channel[2:0], level[12:3], zero pad
  logic                   out_tuser;  // cause
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state: registers, held levels and tick counter
  logic [ACT_W-1:0]    act_chans;
  logic [DB_W-1:0]     band_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic [LEVEL_W-1:0]  held_level [NUM_SAMPLES];
  logic [PERIOD_W-1:0] tick_count;

  logic [IN_TDATA_W-1:0] pending_ticks [$];
  report_word_t          pending_report_words [$];
  int                    walk_base [NUM_SAMPLES];
  int unsigned           queued_cnt;
  int unsigned           accepted_cnt;
  int unsigned           err_cnt;
  int unsigned           cycle_cnt;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;

  multi_channel_deadband_change_reporter_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // scan one accepted tick and queue the snapshot words it causes
  function automatic void scan_tick(input logic [IN_TDATA_W-1:0] word);
    int                 n;
    int                 diff;
    bit                 due;
    bit                 moved;
    bit                 emit;
    logic               cause;
    logic [LEVEL_W-1:0] s;
    report_word_t       w;
    n     = (act_chans > NUM_SAMPLES) ? NUM_SAMPLES : int'(act_chans);
    due   = (tick_count > period_reg);
    moved = 1'b0;
    emit  = 1'b0;
    cause = CAUSE_CHANGE;
    for (int i = 0; i < n && !moved; i++) begin
      s    = word[i*SAMPLE_FIELD_W +: LEVEL_W];
      diff = (s > held_level[i]) ? int'(s) - int'(held_level[i])
                                 : int'(held_level[i]) - int'(s);
      if (diff > int'(band_reg)) begin
        held_level[i] = s;
        moved         = 1'b1;
      end else if (due) begin
        // pending refresh picks up each passed channel on the way
        held_level[i] = s;
      end
    end
    if (moved) begin
      tick_count = '0;
      emit       = 1'b1;
    end else begin
      if (due) begin
        emit       = 1'b1;
        cause      = CAUSE_REFRESH;
        tick_count = '0;
      end
      if (tick_count != COUNT_TOP) tick_count = tick_count + PERIOD_W'(1);
    end
    if (emit) begin
      for (int k = 0; k < n; k++) begin
        w.chan  = k[CHAN_W-1:0];
        w.level = held_level[k];
        w.cause = cause;
        w.last  = (k == n - 1);
        pending_report_words.push_back(w);
      end
    end
  endfunction

  // sender: present the next queued tick once the previous word has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_ticks.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall at random
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // check each output word, then predict from each accepted tick
  always @(posedge clk) begin
    report_word_t got;
    report_word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.chan  = out_tdata[CHAN_W-1:0];
        got.level = out_tdata[CHAN_W +: LEVEL_W];
        got.cause = out_tuser;
        got.last  = out_tlast;
        if (pending_report_words.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word: channel %0d level %0d cause %0d last %0d",
                   $time, got.chan, got.level, got.cause, got.last);
        end else begin
          want = pending_report_words.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display("%0t: word mismatch: expected channel %0d level %0d cause %0d last %0d",
                     $time, want.chan, want.level, want.cause, want.last);
            $display("%0t:                  actual channel %0d level %0d cause %0d last %0d",
                     $time, got.chan, got.level, got.cause, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        scan_tick(in_tdata);
        accepted_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("multi_channel_deadband_change_reporter_unit test failed");
      $finish;
    end
  end

  // write one register and mirror it in the predictor
  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ACTIVE:   act_chans  = value[ACT_W-1:0];
      CFG_DEADBAND: band_reg   = value[DB_W-1:0];
      CFG_PERIOD:   period_reg = value[PERIOD_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned act, input int unsigned band,
                          input int unsigned period);
    write_reg(CFG_ACTIVE, act);
    write_reg(CFG_DEADBAND, band);
    write_reg(CFG_PERIOD, period);
  endtask

  task automatic add_tick(input logic [LEVEL_W-1:0] s0, s1, s2, s3, s4, s5, s6, s7);
    pending_ticks.push_back({s7, s6, s5, s4, s3, s2, s1, s0});
    queued_cnt++;
  endtask

  // random walk around a per-channel base with occasional jumps
  task automatic queue_walk_ticks(input int count, input int band);
    logic [IN_TDATA_W-1:0] word;
    int                    v;
    word = '0;
    for (int t = 0; t < count; t++) begin
      for (int ch = 0; ch < NUM_SAMPLES; ch++) begin
        if ($urandom_range(99) < 7) walk_base[ch] = $urandom_range(LEVEL_MAX);
        v = walk_base[ch] + int'($urandom_range(2 * band + 4)) - band - 2;
        if (v < 0) v = 0;
        else if (v > LEVEL_MAX) v = LEVEL_MAX;
        walk_base[ch] = v;
        word[ch*SAMPLE_FIELD_W +: SAMPLE_FIELD_W] = v[SAMPLE_FIELD_W-1:0];
      end
      pending_ticks.push_back(word);
      queued_cnt++;
    end
  endtask

  // wait until every tick is taken and every word checked, then settle
  task automatic drain_reports();
    @(posedge clk);
    while (accepted_cnt != queued_cnt || pending_report_words.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    act_chans     = ACT_RESET;
    band_reg      = DB_RESET;
    period_reg    = PERIOD_RESET;
    tick_count    = '0;
    queued_cnt    = 0;
    accepted_cnt  = 0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    send_idle_pct = 31;
    recv_idle_pct = 61;
    for (int ch = 0; ch < NUM_SAMPLES; ch++) begin
      held_level[ch] = '0;
      walk_base[ch]  = $urandom_range(LEVEL_MAX);
    end
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: quiet tick, full-scale jump, change on a later channel,
    // deadband edge exactly and one past it
    add_tick(0, 0, 0, 0, 0, 0, 0, 0);
    add_tick(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
    add_tick(1023, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA);
    add_tick(1018, 'h2AA, 0, 0, 0, 0, 0, 0);
    add_tick(1017, 'h2AA, 0, 0, 0, 0, 0, 0);
    add_tick(1017, 'h2AA, 'h155, 'h155, 'h155, 'h155, 'h155, 'h155);
    drain_reports();

    // refresh pending when a later channel changes, then a plain refresh
    set_regs(8, 3, 0);
    add_tick(1017, 'h2AA, 'h155, 0, 0, 0, 0, 0);
    add_tick(1019, 'h2AD, 'h155, 9, 0, 0, 0, 0);
    add_tick(1019, 'h2AD, 'h155, 9, 0, 0, 0, 0);
    add_tick(1017, 'h2AD, 'h155, 9, 2, 1, 0, 3);
    drain_reports();

    // no active channels: counter runs, nothing reported
    set_regs(0, 0, 2);
    queue_walk_ticks(4, 200);
    drain_reports();

    // register above the channel count, widest deadband: refresh only
    set_regs(15, 1023, 1);
    add_tick(0, 0, 0, 0, 0, 0, 0, 0);
    add_tick(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
    add_tick(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
    add_tick(0, 1023, 0, 1023, 0, 1023, 0, 1023);
    drain_reports();

    // random phases under three idle patterns
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 31;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_regs(8, 5, 3);
        1: set_regs(3, 0, 1);
        2: set_regs(1, 20, 0);
        3: set_regs(8, 1023, 2);
        4: set_regs(12, 2, 10);
        5: set_regs(5, 8, 4);
        6: set_regs(7, 1, 65535);
        7: set_regs(8, 50, 6);
        default: set_regs(2, 3, 0);
      endcase
      queue_walk_ticks(22, (band_reg > 60) ? 60 : int'(band_reg));
      drain_reports();
    end

    if (err_cnt == 0) begin
      $display("multi_channel_deadband_change_reporter_unit test passed");
    end else begin
      $display("multi_channel_deadband_change_reporter_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mcdcr_pkg.sv
src/mcdcr_lane.sv
src/mcdcr_merge.sv
src/mcdcr_emit.sv
src/multi_channel_deadband_change_reporter_unit.sv
verif/multi_channel_deadband_change_reporter_unit_tb.sv
